/* design/vertical_bitpack_integer_decoder_defines.svh */
// Assertion macros used by the checker file of the decoder.
`ifndef VERTICAL_BITPACK_INTEGER_DECODER_DEFINES_SVH
`define VERTICAL_BITPACK_INTEGER_DECODER_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define VBD_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define VBD_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that is also checked across reset.
`define VBD_ASSERT_RST(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/vbd_pkg.sv */
package vbd_pkg;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_sel;   // store the beat as the block selector
      logic load_word;  // start a payload lane
      logic step;       // consume one selector bit and one lane bit
      logic emit;       // the current selector bit closes a column
   } vbd_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic sel_slot;       // next beat is a selector
      logic block_sel_zero; // block selector holds no columns
      logic bit_now;        // low bit of the working selector
      logic sel_rest_zero;  // no selector bits above the low one
      logic out_free;       // result register can take a value this cycle
   } vbd_status_type;

endpackage

/* design/vbd_ctrl.sv */
module vbd_ctrl
   import vbd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  vbd_status_type status,
   output vbd_cmd_type    cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (status.sel_slot) begin
                  cmd.load_sel = 1'b1;
               end else begin
                  cmd.load_word = 1'b1;
                  if (!status.block_sel_zero) begin
                     state_in = ST_RUN;
                  end
               end
            end
         end
         ST_RUN: begin
            if (!status.bit_now) begin
               cmd.step = 1'b1;
            end else if (status.out_free) begin
               cmd.step = 1'b1;
               cmd.emit = 1'b1;
               if (status.sel_rest_zero) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

/* design/vbd_datapath.sv */
module vbd_datapath
   import vbd_pkg::*;
#(
   parameter int LANES     = 16,
   parameter int WORD_BITS = 32
) (
   input  logic           clock,
   input  logic           reset,
   input  logic [31:0]    req_input_word,
   input  vbd_cmd_type    cmd,
   output vbd_status_type status,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output logic [31:0]    rsp_decoded_value,
   output logic [8:0]     rsp_position,
   output logic           rsp_last_of_lane
);

   localparam int SLOT_W = $clog2(LANES + 1);
   localparam int K_W    = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

   logic [SLOT_W-1:0]    slot_ff;
   logic [WORD_BITS-1:0] block_sel_ff;
   logic [WORD_BITS-1:0] sel_ff;
   logic [WORD_BITS-1:0] word_ff;
   logic [WORD_BITS-1:0] col_word_ff;
   logic [K_W-1:0]       k_ff;
   logic [8:0]           pos_ff;

   logic                 rsp_valid_ff;
   logic [31:0]          rsp_value_ff;
   logic [8:0]           rsp_pos_ff;
   logic                 rsp_last_ff;

   logic [WORD_BITS+31:0] in_ext;
   logic [WORD_BITS-1:0]  word_in;
   logic [K_W:0]          col_width;
   logic [WORD_BITS-1:0]  col_mask;
   logic [WORD_BITS+31:0] value_ext;

   // Widen before cutting so that any word width maps onto the 32-bit ports.
   assign in_ext    = {{WORD_BITS{1'b0}}, req_input_word};
   assign word_in   = in_ext[WORD_BITS-1:0];
   assign col_width = {1'b0, k_ff} + (K_W + 1)'(1);
   // A shift by the full word width clears all bits, so the mask is all ones.
   assign col_mask  = ~({WORD_BITS{1'b1}} << col_width);
   assign value_ext = {32'd0, col_word_ff & col_mask};

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= '0;
         block_sel_ff <= '0;
      end else if (cmd.load_sel) begin
         block_sel_ff <= word_in;
         slot_ff      <= SLOT_W'(1);
      end else if (cmd.load_word) begin
         slot_ff <= (slot_ff >= SLOT_W'(LANES)) ? '0 : slot_ff + SLOT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_word) begin
         word_ff     <= word_in;
         col_word_ff <= word_in;
         sel_ff      <= block_sel_ff;
         k_ff        <= '0;
         pos_ff      <= 9'(slot_ff - SLOT_W'(1));
      end else if (cmd.step) begin
         sel_ff  <= sel_ff >> 1;
         word_ff <= word_ff >> 1;
         if (cmd.emit) begin
            k_ff        <= '0;
            col_word_ff <= word_ff >> 1;
            pos_ff      <= pos_ff + 9'(LANES);
         end else begin
            k_ff <= k_ff + K_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_value_ff <= value_ext[31:0];
         rsp_pos_ff   <= pos_ff;
         rsp_last_ff  <= status.sel_rest_zero;
      end
   end

   assign status.sel_slot       = (slot_ff == '0);
   assign status.block_sel_zero = (block_sel_ff == '0);
   assign status.bit_now        = sel_ff[0];
   assign status.sel_rest_zero  = ((sel_ff >> 1) == '0);
   assign status.out_free       = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_decoded_value = rsp_value_ff;
   assign rsp_position      = rsp_pos_ff;
   assign rsp_last_of_lane  = rsp_last_ff;

endmodule

/* design/vertical_bitpack_integer_decoder.sv */
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   req_input_word[31:0]
// rsp_      out        rsp_valid/rsp_stall   rsp_decoded_value[31:0], rsp_position[8:0],
//                                            rsp_last_of_lane
//
// A selector beat is taken straight into the selector register. A payload beat is loaded and then
// walked over the selector bit by bit up to its highest set bit; this bit-serial walk of the
// selector yields at most one value a cycle, and none while the result is stalled.
// Reset is synchronous and active high; it clears the slot count, selector and result valid.
// A stalled result holds the walk at the next column end; req_stall is high during a walk.
module vertical_bitpack_integer_decoder
   import vbd_pkg::*;
#(
   parameter int LANES     = 16,
   parameter int WORD_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_input_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_decoded_value,
   output logic [8:0]  rsp_position,
   output logic        rsp_last_of_lane
);

   vbd_cmd_type    cmd;
   vbd_status_type status;

   vbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   vbd_datapath #(
      .LANES     (LANES),
      .WORD_BITS (WORD_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_input_word    (req_input_word),
      .cmd               (cmd),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_decoded_value (rsp_decoded_value),
      .rsp_position      (rsp_position),
      .rsp_last_of_lane  (rsp_last_of_lane)
   );

endmodule

/* design/vbd_checker.sv */
`include "vertical_bitpack_integer_decoder_defines.svh"

module vbd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [31:0] req_input_word,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_decoded_value,
   input logic [8:0]  rsp_position,
   input logic        rsp_last_of_lane
);

   // A result beat can only be produced while a lane is being walked.
   `VBD_ASSERT_IMP(a_rsp_from_walk, $rose(rsp_valid), $past(req_stall), "result beat outside a walk")

   `VBD_ASSERT_NXT(a_rsp_held, rsp_valid && rsp_stall, rsp_valid, "stalled result beat dropped")

   `VBD_ASSERT_NXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(rsp_decoded_value) && $stable(rsp_position) && $stable(rsp_last_of_lane), "stalled result beat changed")

   // Reset leaves the block ready for a selector with no result pending.
   `VBD_ASSERT_RST(a_reset_idle, reset, !rsp_valid && !req_stall, "block busy after reset")

endmodule

bind vertical_bitpack_integer_decoder vbd_checker u_vbd_checker (.*);
